// ===== sv/srgblab_pkg.sv =====
package srgblab_pkg;

  localparam int unsigned CODE_W = 8;
  localparam int unsigned Q_BITS = 30;
  localparam int unsigned LIN_W = 31;
  localparam int unsigned COEF_W = 24;
  localparam int unsigned PROD_W = LIN_W + COEF_W;
  localparam int unsigned XYZ_W = 54;
  localparam int unsigned XYZ_DROP = 22;
  localparam int unsigned T_W = 31;
  localparam int unsigned F_W = 31;
  localparam int unsigned KNEE_N_W = 40;
  localparam int unsigned KNEE_DROP = 8;
  localparam int unsigned KNEE_T_LOW_W = 24;
  localparam int unsigned LAB_W = 42;
  localparam int unsigned L_W = 15;
  localparam int unsigned AB_W = 16;
  localparam int unsigned DIV_LAT = 3;
  localparam int unsigned FRACTION_BITS_DEF = 8;

  localparam longint unsigned DIV_X = 64'd9504700;
  localparam longint unsigned DIV_Y = 64'd10000000;
  localparam longint unsigned DIV_Z = 64'd10888300;
  localparam longint unsigned KNEE_DIV = 64'd3132;
  localparam longint unsigned KNEE_MUL = 64'd24389;
  localparam longint unsigned KNEE_T = (64'd216 * (64'd1 << Q_BITS)) / 64'd24389;
  localparam longint unsigned KNEE_BIAS = 64'd432 * (64'd1 << Q_BITS) + 64'd1566;

  typedef logic [COEF_W-1:0] coef_mat_t [3][3];
  localparam coef_mat_t MATRIX = '{
    '{24'd4124564, 24'd3575761, 24'd1804375},
    '{24'd2126729, 24'd7151522, 24'd721750},
    '{24'd193339,  24'd1191920, 24'd9503041}
  };

  typedef struct packed {
    logic [CODE_W-1:0] red_code;
    logic [CODE_W-1:0] green_code;
    logic [CODE_W-1:0] blue_code;
  } pixel_t;

  typedef struct packed {
    logic [L_W-1:0]         lightness_out;
    logic signed [AB_W-1:0] green_red_axis;
    logic signed [AB_W-1:0] blue_yellow_axis;
  } lab_t;

  typedef logic [LIN_W-1:0] lut_t [256];

  function automatic lut_t build_decode_lut();
    lut_t lut;
    longint unsigned v, w, r, cand, r2, r4, r5, bitm;
    int c;
    for (c = 0; c < 256; c++) begin
      if (c <= 10) begin
        lut[c] = LIN_W'((longint'(c) * 100 * (64'd1 << Q_BITS) + 64'd164730) / 64'd329460);
      end else begin
        v = ((64'd1000 * longint'(c) + 64'd14025) * (64'd1 << Q_BITS) + 64'd134512)
            / 64'd269025;
        w = (v * v + (64'd1 << (Q_BITS - 1))) >> Q_BITS;
        r = 0;
        bitm = 64'd1 << Q_BITS;
        while (bitm != 0) begin
          cand = r | bitm;
          if (cand <= (64'd1 << Q_BITS)) begin
            r2 = (cand * cand) >> Q_BITS;
            r4 = (r2 * r2) >> Q_BITS;
            r5 = (r4 * cand) >> Q_BITS;
            if (r5 <= w) begin
              r = cand;
            end
          end
          bitm = bitm >> 1;
        end
        lut[c] = LIN_W'((w * r + (64'd1 << (Q_BITS - 1))) >> Q_BITS);
      end
    end
    return lut;
  endfunction

  localparam lut_t DECODE_LUT = build_decode_lut();

endpackage

// ===== sv/srgblab_cdiv.sv =====
module srgblab_cdiv #(
  parameter int unsigned      NW   = 54,
  parameter longint unsigned  DIV  = 64'd9504700,
  parameter int unsigned      DROP = 22,
  parameter int unsigned      QW   = 31
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] n_i,
  output logic          valid_o,
  output logic [QW-1:0] q_o
);
  import srgblab_pkg::*;

  localparam longint unsigned RECIP = (64'd1 << (DROP + 32)) / DIV;
  localparam logic [31:0] RECIP32 = 32'(RECIP);
  localparam int unsigned RW = $clog2(4 * DIV);

  logic [31:0]   n_hi;
  logic [63:0]   p1;
  logic [QW-1:0] q0_d, q0_q, q0b_q, q_d, q_q, inc;
  logic [NW-1:0] n1_q, n2_q, prod_d, prod_q;
  logic [RW-1:0] rem;
  logic          v1_q, v2_q, v3_q;

  assign n_hi   = 32'(n_i >> DROP);
  assign p1     = 64'(n_hi) * 64'(RECIP32);
  assign q0_d   = QW'(p1 >> 32);
  assign prod_d = NW'(q0_q) * NW'(DIV);
  assign rem    = RW'(n2_q - prod_q);
  assign inc    = QW'(rem >= RW'(DIV)) + QW'(rem >= RW'(2 * DIV)) + QW'(rem >= RW'(3 * DIV));
  assign q_d    = q0b_q + inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    q0_q   <= q0_d;
    n1_q   <= n_i;
    prod_q <= prod_d;
    n2_q   <= n1_q;
    q0b_q  <= q0_q;
    q_q    <= q_d;
  end

  assign valid_o = v3_q;
  assign q_o     = q_q;

endmodule

// ===== sv/srgblab_cbrt.sv =====
module srgblab_cbrt #(
  parameter int unsigned TW = 31,
  parameter int unsigned CW = 31
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [TW-1:0] t_i,
  output logic          valid_o,
  output logic [TW-1:0] t_o,
  output logic [CW-1:0] c_o
);
  import srgblab_pkg::*;

  localparam int unsigned SQW = 2 * CW;
  localparam int unsigned C2W = SQW - Q_BITS;
  localparam int unsigned PW  = C2W + CW;
  localparam int unsigned KW  = PW - Q_BITS;

  logic [CW-1:0]  ac_q  [CW];
  logic [CW-1:0]  ao_q  [CW];
  logic [SQW-1:0] acsq_q [CW];
  logic [SQW-1:0] aos_q [CW];
  logic [TW-1:0]  at_q  [CW];
  logic           av_q  [CW];
  logic [CW-1:0]  c_q   [CW];
  logic [SQW-1:0] sq_q  [CW];
  logic [TW-1:0]  t_q   [CW];
  logic           v_q   [CW];

  for (genvar i = 0; i < CW; i++) begin : g_bit
    localparam int unsigned K = CW - 1 - i;
    logic [CW-1:0]  c_in, cand_d;
    logic [SQW-1:0] sq_in, csq_d;
    logic [TW-1:0]  t_in;
    logic           v_in;
    logic [C2W-1:0] c2;
    logic [PW-1:0]  prod;
    logic           take;

    if (i == 0) begin : g_first
      assign c_in  = '0;
      assign sq_in = '0;
      assign t_in  = t_i;
      assign v_in  = valid_i;
    end else begin : g_next
      assign c_in  = c_q[i-1];
      assign sq_in = sq_q[i-1];
      assign t_in  = t_q[i-1];
      assign v_in  = v_q[i-1];
    end

    assign cand_d = c_in | (CW'(1) << K);
    assign csq_d  = sq_in + (SQW'(c_in) << (K + 1)) + (SQW'(1) << (2 * K));
    assign c2     = acsq_q[i][SQW-1:Q_BITS];
    assign prod   = PW'(c2) * PW'(ac_q[i]);
    assign take   = prod[PW-1:Q_BITS] <= KW'(at_q[i]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        av_q[i] <= 1'b0;
        v_q[i]  <= 1'b0;
      end else begin
        av_q[i] <= v_in;
        v_q[i]  <= av_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      ac_q[i]   <= cand_d;
      acsq_q[i] <= csq_d;
      ao_q[i]   <= c_in;
      aos_q[i]  <= sq_in;
      at_q[i]   <= t_in;
      c_q[i]    <= take ? ac_q[i] : ao_q[i];
      sq_q[i]   <= take ? acsq_q[i] : aos_q[i];
      t_q[i]    <= at_q[i];
    end
  end

  assign valid_o = v_q[CW-1];
  assign t_o     = t_q[CW-1];
  assign c_o     = c_q[CW-1];

endmodule

// ===== sv/srgb_to_cielab_converter_core.sv =====
// sRGB (8-bit codes) to CIE L*a*b* under D65, L*, a* and b* out as fixed point with
// FRACTION_BITS fraction bits, rounded to nearest and saturated. A pixel is taken on
// any cycle with start high; busy never rises, so one pixel per clock is sustained.
// Each result shows on lab_o for one cycle with done_o, in pixel order; the sink must
// take it then, as nothing holds it. Between pixel and result lie the transfer table,
// matrix, and two constant dividers of three stages each, plus the cube root, which
// resolves one bit per two pipeline stages (62 stages).
module srgb_to_cielab_converter_core #(
  parameter int unsigned FRACTION_BITS = srgblab_pkg::FRACTION_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  srgblab_pkg::pixel_t  pixel_i,
  output logic                 done_o,
  output srgblab_pkg::lab_t    lab_o
);
  import srgblab_pkg::*;

  localparam int unsigned LATENCY = 3 + DIV_LAT + 2 * F_W + 1 + DIV_LAT + 2;
  localparam int unsigned SCW  = LAB_W + FRACTION_BITS;
  localparam int unsigned RNDW = SCW - Q_BITS;
  localparam longint unsigned XYZ_DIV [3] = '{DIV_X, DIV_Y, DIV_Z};
  localparam logic signed [LAB_W-1:0] L_MUL   = LAB_W'(116);
  localparam logic signed [LAB_W-1:0] L_OFS   = LAB_W'(16) << Q_BITS;
  localparam logic signed [LAB_W-1:0] A_MUL   = LAB_W'(500);
  localparam logic signed [LAB_W-1:0] B_MUL   = LAB_W'(200);
  localparam logic signed [SCW-1:0]   HALF_S  = SCW'(1) << (Q_BITS - 1);
  localparam logic signed [RNDW-1:0]  L_MAX   = RNDW'(32767);
  localparam logic signed [RNDW-1:0]  AB_MAX  = RNDW'(32767);
  localparam logic signed [RNDW-1:0]  AB_MIN  = RNDW'(-32'sd32768);

  logic [CODE_W-1:0]  code   [3];
  logic [LIN_W-1:0]   lin_q  [3];
  logic [PROD_W-1:0]  prod_q [3][3];
  logic [XYZ_W-1:0]   sum_q  [3];
  logic               v1_q, v2_q, v3_q;

  logic [T_W-1:0]     t_div  [3];
  logic               vdiv   [3];
  logic [T_W-1:0]     t_cb   [3];
  logic [F_W-1:0]     c_cb   [3];
  logic               vcb    [3];

  logic [KNEE_N_W-1:0] kn_q  [3];
  logic                vk_q;
  logic [F_W-1:0]      cp_q  [DIV_LAT+1][3];
  logic                ap_q  [DIV_LAT+1][3];
  logic [F_W-1:0]      lin_f [3];
  logic                vlin  [3];
  logic [F_W-1:0]      f     [3];

  logic signed [LAB_W-1:0] fxs, fys, fzs;
  logic signed [LAB_W-1:0] light_q, av_q, bv_q;
  logic                    vlab_q;
  logic signed [RNDW-1:0]  rl, ra, rb;
  lab_t                    lab_d, lab_q;
  logic                    done_q;

  assign busy    = 1'b0;
  assign code[0] = pixel_i.red_code;
  assign code[1] = pixel_i.green_code;
  assign code[2] = pixel_i.blue_code;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      vk_q   <= 1'b0;
      vlab_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      vk_q   <= vcb[0] & vcb[1] & vcb[2];
      vlab_q <= vlin[0] & vlin[1] & vlin[2];
      done_q <= vlab_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      lin_q[r] <= DECODE_LUT[code[r]];
      for (int c = 0; c < 3; c++) begin
        prod_q[r][c] <= PROD_W'(MATRIX[r][c]) * PROD_W'(lin_q[c]);
      end
      sum_q[r] <= XYZ_W'(prod_q[r][0] + prod_q[r][1] + prod_q[r][2]
                         + PROD_W'(XYZ_DIV[r] / 2));
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    srgblab_cdiv #(
      .NW  (XYZ_W),
      .DIV (XYZ_DIV[ch]),
      .DROP(XYZ_DROP),
      .QW  (T_W)
    ) u_xyz_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(v3_q),
      .n_i    (sum_q[ch]),
      .valid_o(vdiv[ch]),
      .q_o    (t_div[ch])
    );

    srgblab_cbrt #(
      .TW(T_W),
      .CW(F_W)
    ) u_cbrt (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(vdiv[ch]),
      .t_i    (t_div[ch]),
      .valid_o(vcb[ch]),
      .t_o    (t_cb[ch]),
      .c_o    (c_cb[ch])
    );

    always_ff @(posedge clk_i) begin
      kn_q[ch]     <= KNEE_N_W'(KNEE_N_W'(KNEE_MUL) * KNEE_N_W'(t_cb[ch][KNEE_T_LOW_W-1:0]))
                      + KNEE_N_W'(KNEE_BIAS);
      cp_q[0][ch]  <= c_cb[ch];
      ap_q[0][ch]  <= t_cb[ch] > T_W'(KNEE_T);
      for (int j = 1; j <= DIV_LAT; j++) begin
        cp_q[j][ch] <= cp_q[j-1][ch];
        ap_q[j][ch] <= ap_q[j-1][ch];
      end
    end

    srgblab_cdiv #(
      .NW  (KNEE_N_W),
      .DIV (KNEE_DIV),
      .DROP(KNEE_DROP),
      .QW  (F_W)
    ) u_knee_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(vk_q),
      .n_i    (kn_q[ch]),
      .valid_o(vlin[ch]),
      .q_o    (lin_f[ch])
    );

    assign f[ch] = ap_q[DIV_LAT][ch] ? cp_q[DIV_LAT][ch] : lin_f[ch];
  end

  assign fxs = $signed(LAB_W'(f[0]));
  assign fys = $signed(LAB_W'(f[1]));
  assign fzs = $signed(LAB_W'(f[2]));

  always_ff @(posedge clk_i) begin
    light_q <= fys * L_MUL - L_OFS;
    av_q    <= (fxs - fys) * A_MUL;
    bv_q    <= (fys - fzs) * B_MUL;
  end

  function automatic logic signed [RNDW-1:0] round_q(input logic signed [LAB_W-1:0] v);
    logic signed [SCW-1:0] s;
    s = $signed({v, FRACTION_BITS'(0)}) + HALF_S;
    return $signed(s[SCW-1:Q_BITS]);
  endfunction

  assign rl = round_q(light_q);
  assign ra = round_q(av_q);
  assign rb = round_q(bv_q);

  always_comb begin
    lab_d = '0;
    if (rl < 0) begin
      lab_d.lightness_out = '0;
    end else if (rl > L_MAX) begin
      lab_d.lightness_out = L_W'(L_MAX);
    end else begin
      lab_d.lightness_out = L_W'(rl);
    end
    if (ra < AB_MIN) begin
      lab_d.green_red_axis = AB_W'(AB_MIN);
    end else if (ra > AB_MAX) begin
      lab_d.green_red_axis = AB_W'(AB_MAX);
    end else begin
      lab_d.green_red_axis = AB_W'(ra);
    end
    if (rb < AB_MIN) begin
      lab_d.blue_yellow_axis = AB_W'(AB_MIN);
    end else if (rb > AB_MAX) begin
      lab_d.blue_yellow_axis = AB_W'(AB_MAX);
    end else begin
      lab_d.blue_yellow_axis = AB_W'(rb);
    end
  end

  always_ff @(posedge clk_i) begin
    lab_q <= lab_d;
  end

  assign done_o = done_q;
  assign lab_o  = lab_q;

  a_beat_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##LATENCY done_o)
    else $error("pixel beat did not leave after the pipeline latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LATENCY))
    else $error("result beat without a matching pixel beat");

endmodule
